// ----- rtl/bpa_pkg.sv -----
`default_nettype none
package bpa_pkg;
  localparam int ZonePages = 4096;
  localparam int NumOrders = 11;
  localparam int IdxW = 12;
  localparam int CntW = 13;
  localparam int OrdW = 4;
  localparam logic [OrdW-1:0] TagNone = 4'd15;

  typedef enum logic {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_kind_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_DECODE, S_ASCAN, S_FTAG,
    S_UL_RD, S_UL_WR,
    S_PU_RD, S_PU_WR1, S_PU_WR2,
    S_SPLIT, S_MCHK, S_MWAIT, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/bpa_link_ram.sv -----
`default_nettype none
module bpa_link_ram (
  input  wire logic clk,
  input  wire logic wr_en,
  input  wire logic [bpa_pkg::IdxW-1:0] wr_addr,
  input  wire logic [bpa_pkg::IdxW-1:0] wr_data,
  input  wire logic [bpa_pkg::IdxW-1:0] rd_addr,
  output logic [bpa_pkg::IdxW-1:0] rd_data
);
  import bpa_pkg::*;
  logic [IdxW-1:0] mem [ZonePages];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- rtl/bpa_tag_ram.sv -----
`default_nettype none
module bpa_tag_ram (
  input  wire logic clk,
  input  wire logic wr_en,
  input  wire logic [bpa_pkg::IdxW-1:0] wr_addr,
  input  wire logic [bpa_pkg::OrdW-1:0] wr_data,
  input  wire logic [bpa_pkg::IdxW-1:0] rd_addr,
  output logic [bpa_pkg::OrdW-1:0] rd_data
);
  import bpa_pkg::*;
  logic [OrdW-1:0] mem [ZonePages];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- rtl/buddy_page_allocator_top.sv -----
`default_nettype none
// Channel   Dir  Contents
// s_axis    in   tdata: order[3:0], page_index[15:4]; tuser: req_type
// m_axis    out  tdata: page_index_out[11:0], free_page_count[24:12]; tuser: ok
// cfg       in   zone_size write, taken whenever cfg_we is high
// After reset a clearing pass over all 4096 pages sets every head tag to "not a
// free head"; no request is taken meanwhile.
// A request rejected at once goes from decode to done. The scan looks at one
// order per cycle; an unlink is a read state and, unless one block was listed,
// a write state; a push is a read state and, into a non-empty list, two writes.
// The result register lets the next request start while a result waits; a
// request that finishes before that result is taken holds in the done state.
module buddy_page_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // order, page_index
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // page_index_out, free_page_count
  output logic             m_axis_tuser   // ok
);
  import bpa_pkg::*;

  state_t state, state_next;
  logic [CntW-1:0] zone_size;
  logic [IdxW-1:0] first_blk [NumOrders];
  logic [CntW-1:0] list_count [NumOrders];
  logic [CntW-1:0] avail_pages;
  logic [IdxW-1:0] clr_idx;
  logic            rtype;
  logic [OrdW-1:0] ord, hi, cur, uk, pk;
  logic [IdxW-1:0] pg, h, ux, px, pu_t;
  logic            ret_split;   // after unlink/push return to split; else unlink goes to merge, push to done
  logic            res_ok;
  logic [IdxW-1:0] res_pg;
  logic            o_ok;
  logic [IdxW-1:0] o_pg;
  logic [CntW-1:0] o_cnt;

  // memory ports
  logic            nx_we, pv_we, tg_we;
  logic [IdxW-1:0] nx_wa, nx_wd, nx_ra, nx_rd, pv_wa, pv_wd, pv_ra, pv_rd, tg_wa, tg_ra;
  logic [OrdW-1:0] tg_wd, tg_rd;

  bpa_link_ram u_next (.clk, .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
                       .rd_addr(nx_ra), .rd_data(nx_rd));
  bpa_link_ram u_prev (.clk, .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
                       .rd_addr(pv_ra), .rd_data(pv_rd));
  bpa_tag_ram  u_tag  (.clk, .wr_en(tg_we), .wr_addr(tg_wa), .wr_data(tg_wd),
                       .rd_addr(tg_ra), .rd_data(tg_rd));

  logic [CntW-1:0] zeff;
  assign zeff = (zone_size > CntW'(ZonePages)) ? CntW'(ZonePages) : zone_size;

  logic [CntW-1:0] sz;
  assign sz = CntW'(1) << ord;

  logic [IdxW-1:0] buddy;
  assign buddy = pg ^ (IdxW'(1) << ord);

  logic [CntW-1:0] split_b;
  assign split_b = {1'b0, h} + (CntW'(1) << (hi - OrdW'(1)));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tuser  = o_ok;
  assign m_axis_tdata  = {7'd0, o_cnt, o_pg};

  always_comb begin
    state_next = state;
    nx_we = 1'b0; nx_wa = px; nx_wd = px; nx_ra = ux;
    pv_we = 1'b0; pv_wa = px; pv_wd = px; pv_ra = ux;
    tg_we = 1'b0; tg_wa = clr_idx; tg_wd = TagNone; tg_ra = pg;
    case (state)
      S_CLEAR: begin
        tg_we = 1'b1;
        if (clr_idx == IdxW'(ZonePages - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (s_axis_tvalid) state_next = S_DECODE;
      S_DECODE: begin
        if (ord >= OrdW'(NumOrders)) state_next = S_DONE;
        else if (rtype == REQ_ALLOC) state_next = (zone_size == '0) ? S_DONE : S_ASCAN;
        else state_next = S_FTAG;
      end
      S_ASCAN: begin
        // one order per cycle
        if (cur >= OrdW'(NumOrders)) state_next = S_DONE;
        else if (list_count[cur] != '0) state_next = S_UL_RD;
      end
      S_FTAG: begin
        if ((pg & IdxW'(sz - CntW'(1))) != '0 || ({1'b0, pg} + sz) > zeff ||
            tg_rd != TagNone) state_next = S_DONE;
        else state_next = S_MCHK;
      end
      S_MCHK: begin
        tg_ra = buddy;
        if (ord + OrdW'(1) >= OrdW'(NumOrders) || {1'b0, buddy} >= zeff)
          state_next = S_PU_RD;
        else state_next = S_MWAIT;
      end
      S_MWAIT: state_next = (tg_rd == ord) ? S_UL_RD : S_PU_RD;
      S_UL_RD: begin
        tg_we = 1'b1; tg_wa = ux; tg_wd = TagNone;
        if (list_count[uk] > CntW'(1)) state_next = S_UL_WR;
        else state_next = ret_split ? S_SPLIT : S_MCHK;
      end
      S_UL_WR: begin
        nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
        pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
        state_next = ret_split ? S_SPLIT : S_MCHK;
      end
      S_SPLIT: begin
        if (hi == ord) state_next = S_DONE;
        else if (split_b < CntW'(ZonePages)) state_next = S_PU_RD;
      end
      S_PU_RD: begin
        pv_ra = first_blk[pk];
        if (list_count[pk] == '0) begin
          nx_we = 1'b1; nx_wa = px; nx_wd = px;
          pv_we = 1'b1; pv_wa = px; pv_wd = px;
          tg_we = 1'b1; tg_wa = px; tg_wd = pk;
          state_next = ret_split ? S_SPLIT : S_DONE;
        end else begin
          state_next = S_PU_WR1;
        end
      end
      S_PU_WR1: begin
        // The new block's own links first, then its neighbors.
        nx_we = 1'b1; nx_wa = px; nx_wd = first_blk[pk];
        pv_we = 1'b1; pv_wa = px; pv_wd = pv_rd;
        tg_we = 1'b1; tg_wa = px; tg_wd = pk;
        state_next = S_PU_WR2;
      end
      S_PU_WR2: begin
        nx_we = 1'b1; nx_wa = pu_t; nx_wd = px;
        pv_we = 1'b1; pv_wa = first_blk[pk]; pv_wd = px;
        state_next = ret_split ? S_SPLIT : S_DONE;
      end
      S_DONE: if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      zone_size <= '0;
      avail_pages <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NumOrders; i++) begin
        first_blk[i] <= '0;
        list_count[i] <= '0;
      end
    end else begin
      if (cfg_we) zone_size <= cfg_wdata;
      if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        o_ok <= res_ok;
        o_pg <= res_pg;
        o_cnt <= avail_pages;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_idx <= clr_idx + IdxW'(1);
        S_IDLE: if (s_axis_tvalid) begin
          rtype <= s_axis_tuser;
          ord <= s_axis_tdata[3:0];
          pg <= s_axis_tdata[15:4];
          cur <= s_axis_tdata[3:0];
          res_ok <= 1'b0; res_pg <= '0;
        end
        S_ASCAN: if (cur < OrdW'(NumOrders)) begin
          if (list_count[cur] != '0) begin
            h <= first_blk[cur];
            ux <= first_blk[cur];
            uk <= cur; hi <= cur; ret_split <= 1'b1;
          end else cur <= cur + OrdW'(1);
        end
        S_FTAG: if (state_next == S_MCHK) begin
          avail_pages <= (avail_pages + sz > CntW'(ZonePages)) ?
                         CntW'(ZonePages) : avail_pages + sz;
        end
        S_MCHK: begin
          ux <= buddy; uk <= ord; ret_split <= 1'b0;
          px <= pg; pk <= ord;
        end
        S_UL_RD: begin
          if (list_count[uk] != '0) list_count[uk] <= list_count[uk] - CntW'(1);
          if (list_count[uk] <= CntW'(1) && !ret_split) begin
            pg <= pg & ux;
            ord <= ord + OrdW'(1);
          end
        end
        S_UL_WR: begin
          if (first_blk[uk] == ux) first_blk[uk] <= nx_rd;
          if (!ret_split) begin
            pg <= pg & ux;
            ord <= ord + OrdW'(1);
          end
        end
        S_SPLIT: begin
          if (hi == ord) begin
            avail_pages <= (avail_pages > sz) ? avail_pages - sz : '0;
            res_ok <= 1'b1; res_pg <= h;
          end else begin
            hi <= hi - OrdW'(1);
            px <= split_b[IdxW-1:0]; pk <= hi - OrdW'(1);
          end
        end
        S_PU_RD: if (list_count[pk] == '0) begin
          first_blk[pk] <= px;
          list_count[pk] <= list_count[pk] + CntW'(1);
          if (!ret_split) begin res_ok <= 1'b1; res_pg <= px; end
        end
        S_PU_WR1: pu_t <= pv_rd;
        S_PU_WR2: begin
          first_blk[pk] <= px;
          list_count[pk] <= list_count[pk] + CntW'(1);
          if (!ret_split) begin res_ok <= 1'b1; res_pg <= px; end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
